// ----- rtl/core/i2ceep_pkg.sv -----
// Package: shared types and constants for the EEPROM random-access I2C master.
`timescale 1ns / 1ps
package i2ceep_pkg;

	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd50;

	localparam int SLOT_COUNT = 5;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	// request byte slots
	localparam logic [SLOT_W-1:0] SLOT_DEV_WRITE = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_ADDR_HIGH = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_ADDR_LOW  = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_DATA      = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_DEV_READ  = SLOT_W'(4);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	// one phase tick with request fields
	typedef struct packed {
		logic       start_request;
		logic       kind;
		logic [7:0] device_write_byte;
		logic [7:0] device_read_byte;
		logic [7:0] address_high;
		logic [7:0] address_low;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	// bus levels and status after one phase
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} result_t;

endpackage

// ----- rtl/core/i2ceep_seq.sv -----
// Phase sequencer: START, byte shifting, ACK polling, read shift-in, NACK and STOP.
`timescale 1ns / 1ps
module i2ceep_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          ack_timeout,
	input  i2ceep_pkg::item_t   item,
	output i2ceep_pkg::result_t result
);
	import i2ceep_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,  PH_S1    = 5'd1,  PH_S2    = 5'd2,  PH_S3    = 5'd3,
		PH_BLOW  = 5'd4,  PH_BDATA = 5'd5,  PH_BHIGH = 5'd6,  PH_BFALL = 5'd7,
		PH_AREL  = 5'd8,  PH_ACLK  = 5'd9,  PH_AWAIT = 5'd10, PH_AFALL = 5'd11,
		PH_RREL  = 5'd12, PH_RLOW  = 5'd13, PH_RHIGH = 5'd14, PH_NLOW  = 5'd15,
		PH_NHIGH = 5'd16, PH_NFALL = 5'd17, PH_P1    = 5'd18, PH_P2    = 5'd19,
		PH_P3    = 5'd20
	} phase_t;

	phase_t      phase_q, phase_d, phase_cur;
	logic [1:0]  byte_idx_q, byte_idx_d, byte_idx_inc;
	logic [3:0]  bit_cnt_q, bit_cnt_d, bit_cnt_inc;
	logic [7:0]  tx_shift_q, tx_shift_d;
	logic [7:0]  rx_shift_q, rx_shift_d;
	logic [7:0]  wait_cnt_q, wait_cnt_d;
	logic        is_read_q, is_read_d;
	logic        nack_q, nack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        done_d;
	logic        start;
	logic [SLOT_W-1:0] load_slot;
	logic [7:0]  req_bytes_q [SLOT_COUNT];

	assign start        = (phase_q == PH_IDLE) && item.start_request;
	assign byte_idx_inc = byte_idx_q + 2'd1;
	assign bit_cnt_inc  = bit_cnt_q + 4'd1;

	// slot of the next byte; the fourth byte of a read is the device read byte
	always_comb begin
		load_slot = SLOT_W'(byte_idx_inc);
		if (is_read_q && (byte_idx_inc == 2'd3)) begin
			load_slot = SLOT_DEV_READ;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		bit_cnt_d  = bit_cnt_q;
		tx_shift_d = tx_shift_q;
		rx_shift_d = rx_shift_q;
		wait_cnt_d = wait_cnt_q;
		is_read_d  = is_read_q;
		nack_d     = nack_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		done_d     = 1'b0;
		phase_cur  = phase_q;

		if (start) begin
			is_read_d  = item.kind;
			nack_d     = 1'b0;
			byte_idx_d = 2'd0;
			tx_shift_d = item.device_write_byte;
			bit_cnt_d  = 4'd0;
			phase_cur  = PH_S1;
		end

		unique case (phase_cur)
			PH_S1: begin
				sda_d = 1'b1; phase_d = PH_S2;
			end
			PH_S2: begin
				scl_d = 1'b1; phase_d = PH_S3;
			end
			PH_S3: begin
				sda_d = 1'b0; phase_d = PH_BLOW;
			end
			PH_BLOW: begin
				scl_d = 1'b0; phase_d = PH_BDATA;
			end
			PH_BDATA: begin
				sda_d = tx_shift_q[7]; phase_d = PH_BHIGH;
			end
			PH_BHIGH: begin
				scl_d = 1'b1; phase_d = PH_BFALL;
			end
			PH_BFALL: begin
				scl_d      = 1'b0;
				tx_shift_d = {tx_shift_q[6:0], 1'b0};
				bit_cnt_d  = bit_cnt_inc;
				phase_d    = (bit_cnt_inc >= 4'd8) ? PH_AREL : PH_BLOW;
			end
			PH_AREL: begin
				sda_d      = 1'b1;
				wait_cnt_d = 8'd0;
				phase_d    = PH_ACLK;
			end
			PH_ACLK: begin
				scl_d = 1'b1; phase_d = PH_AWAIT;
			end
			PH_AWAIT: begin
				if (!item.sda_in) begin
					phase_d = PH_AFALL;
				end else if (wait_cnt_q < ack_timeout) begin
					wait_cnt_d = wait_cnt_q + 8'd1;
				end else begin
					nack_d  = 1'b1;
					phase_d = PH_AFALL;
				end
			end
			PH_AFALL: begin
				scl_d = 1'b0;
				if (byte_idx_q != 2'd3) begin
					byte_idx_d = byte_idx_inc;
					tx_shift_d = req_bytes_q[load_slot];
					bit_cnt_d  = 4'd0;
					// reads go back through a repeated START before the device read byte
					phase_d    = (is_read_q && (byte_idx_inc == 2'd3)) ? PH_S1 : PH_BLOW;
				end else if (is_read_q) begin
					bit_cnt_d = 4'd0;
					phase_d   = PH_RREL;
				end else begin
					phase_d = PH_P1;
				end
			end
			PH_RREL: begin
				sda_d = 1'b1; phase_d = PH_RLOW;
			end
			PH_RLOW: begin
				scl_d = 1'b0; phase_d = PH_RHIGH;
			end
			PH_RHIGH: begin
				scl_d      = 1'b1;
				rx_shift_d = {rx_shift_q[6:0], item.sda_in};
				bit_cnt_d  = bit_cnt_inc;
				phase_d    = (bit_cnt_inc >= 4'd8) ? PH_NLOW : PH_RREL;
			end
			PH_NLOW: begin
				scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_NHIGH;
			end
			PH_NHIGH: begin
				scl_d = 1'b1; phase_d = PH_NFALL;
			end
			PH_NFALL: begin
				scl_d = 1'b0; phase_d = PH_P1;
			end
			PH_P1: begin
				sda_d = 1'b0; phase_d = PH_P2;
			end
			PH_P2: begin
				scl_d = 1'b1; phase_d = PH_P3;
			end
			PH_P3: begin
				sda_d   = 1'b1;
				done_d  = 1'b1;
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			byte_idx_q <= 2'd0;
			bit_cnt_q  <= 4'd0;
			tx_shift_q <= 8'd0;
			rx_shift_q <= 8'd0;
			wait_cnt_q <= 8'd0;
			is_read_q  <= 1'b0;
			nack_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else if (step_en) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			bit_cnt_q  <= bit_cnt_d;
			tx_shift_q <= tx_shift_d;
			rx_shift_q <= rx_shift_d;
			wait_cnt_q <= wait_cnt_d;
			is_read_q  <= is_read_d;
			nack_q     <= nack_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
		end
	end

	// request bytes, written on every start
	always_ff @(posedge clk) begin
		if (step_en && start) begin
			req_bytes_q[SLOT_DEV_WRITE] <= item.device_write_byte;
			req_bytes_q[SLOT_ADDR_HIGH] <= item.address_high;
			req_bytes_q[SLOT_ADDR_LOW]  <= item.address_low;
			req_bytes_q[SLOT_DATA]      <= item.write_data;
			req_bytes_q[SLOT_DEV_READ]  <= item.device_read_byte;
		end
	end

	assign result.scl_level   = scl_d;
	assign result.sda_level   = sda_d;
	assign result.busy_res    = (phase_d != PH_IDLE);
	assign result.done_res    = done_d;
	assign result.read_data   = rx_shift_d;
	assign result.ack_missing = nack_d;

endmodule

// ----- rtl/core/i2c_eeprom_random_access_master.sv -----
// Top level: stream wrapper around the EEPROM random-access I2C phase sequencer.
`timescale 1ns / 1ps
// Bit-level I2C master for EEPROMs with a two-byte memory address. Each input
// transaction is one bus phase tick: it carries a start strobe with the
// request bytes and the SDA level sampled in that phase, and yields exactly
// one output transaction with the SCL/SDA levels to drive after the phase plus
// status. Throughput is one transaction per clock while results are taken: the
// phase sequencer takes one step per accepted tick and its result lands in the
// output register, valid in the cycle after the tick is accepted. A new tick
// enters in the same cycle the waiting result is taken; while a result sits
// unread the input stalls.
// A write runs START, device write byte, address high, address low, data,
// each with an ACK wait, then STOP. A read sends the device write byte and
// both address bytes, a repeated START and the device read byte, shifts in 8
// bits MSB first, then sends NACK and STOP. An ACK wait polls SDA for up to
// ack_timeout extra phases; a timeout sets ack_missing and the sequence goes on.
// A start strobe while busy is ignored. The user writes ack_timeout (reset value
// 50) through cfg_write_en / cfg_write_data only while idle; the block won't check.
module i2c_eeprom_random_access_master (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [7:0]                         cfg_write_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [0] start_request, [8:1] device_write_byte, [16:9] device_read_byte,
	// [24:17] address_high, [32:25] address_low, [40:33] write_data, [41] sda_in
	input  logic [i2ceep_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] kind
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
	// [11:4] read_data, [12] ack_missing
	output logic [i2ceep_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import i2ceep_pkg::*;

	logic       ack_timeout_q;
	logic [7:0] ack_timeout_val_q;
	logic       accept;
	logic       m_tvalid_q;
	item_t      item;
	result_t    result;
	result_t    result_q;

	// output register frees up whenever it is empty or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign item.start_request     = s_tdata[0];
	assign item.kind              = s_tuser;
	assign item.device_write_byte = s_tdata[8:1];
	assign item.device_read_byte  = s_tdata[16:9];
	assign item.address_high      = s_tdata[24:17];
	assign item.address_low       = s_tdata[32:25];
	assign item.write_data        = s_tdata[40:33];
	assign item.sda_in            = s_tdata[41];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_val_q <= ACK_TIMEOUT_RESET;
			ack_timeout_q     <= 1'b0;
		end else begin
			ack_timeout_q <= cfg_write_en;
			if (cfg_write_en) begin
				ack_timeout_val_q <= cfg_write_data;
			end
		end
	end

	i2ceep_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (accept),
		.ack_timeout (ack_timeout_val_q),
		.item        (item),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, result_q.ack_missing, result_q.read_data,
	                   result_q.done_res, result_q.busy_res,
	                   result_q.sda_level, result_q.scl_level};

`ifndef SYNTHESIS
	// finishing STOP always leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done reported while still busy");

	// an empty output register never stalls the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// a configuration write lands in the timeout register
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		ack_timeout_q |-> ack_timeout_val_q == $past(cfg_write_data))
		else $error("ack timeout write lost");
`endif

endmodule

// ----- tb/sv/tb_i2c_eeprom_random_access_master.sv -----
// Testbench: phase-accurate predictor and scoreboard for the EEPROM random-access I2C master.
`timescale 1ns / 1ps
// What is checked: every output transaction (SCL/SDA levels, busy, done,
// read byte, missing-ACK flag) against a local model of the phase sequencer.
// The sender shapes SDA so the ACK polls and read bits are exercised:
// - mostly prompt ACKs, sometimes a whole transaction of SDA held high,
//   which drives every ACK wait into its timeout;
// - now and then a fully noisy transaction.
// Start strobes while busy carry random bytes, which the block must ignore.
// ack_timeout is swept through its reset value, 0, 1, 255, a random value
// and 3. It is only written with the sequencer idle and no result in flight.

module tb_i2c_eeprom_random_access_master;

	import i2ceep_pkg::*;

	localparam int STALL_LIMIT = 5000;  // cycles with no transaction on either side
	localparam int MAX_REPORTS = 10;

	// Bus phases of the sequencer, in step order
	typedef enum logic [4:0] {
		SEQ_IDLE,
		START_SDA_HIGH, START_SCL_HIGH, START_SDA_LOW,
		BIT_SCL_LOW, BIT_DATA, BIT_SCL_HIGH, BIT_SCL_FALL,
		ACK_RELEASE, ACK_CLOCK, ACK_POLL, ACK_FALL,
		RX_RELEASE, RX_SCL_LOW, RX_SCL_HIGH,
		NACK_LOW, NACK_HIGH, NACK_FALL,
		STOP_SDA_LOW, STOP_SCL_HIGH, STOP_SDA_HIGH
	} seq_phase_t;

	// Tracks the sequencer and holds the bus levels expected for each tick
	class i2c_level_scoreboard;
		seq_phase_t  phase;
		logic [2:0]  byte_index;
		logic [3:0]  bit_count;
		logic [7:0]  tx_shift;
		logic [7:0]  rx_shift;
		logic [7:0]  wait_count;
		logic [7:0]  req_bytes [SLOT_COUNT];
		logic        reading;
		logic        ack_lost;
		logic        scl_drive;
		logic        sda_drive;
		logic [7:0]  ack_limit;
		result_t     expected_levels [$];
		int          mismatches;

		function new();
			phase      = SEQ_IDLE;
			byte_index = '0;
			bit_count  = '0;
			tx_shift   = '0;
			rx_shift   = '0;
			wait_count = '0;
			foreach (req_bytes[i]) req_bytes[i] = '0;
			reading    = 1'b0;
			ack_lost   = 1'b0;
			scl_drive  = 1'b1;
			sda_drive  = 1'b1;
			ack_limit  = ACK_TIMEOUT_RESET;
			mismatches = 0;
		endfunction

		function void set_timeout(logic [7:0] value);
			ack_limit = value;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		// byte 3 is the data byte on writes and the device read byte on reads
		function void load_byte();
			int unsigned slot;
			slot = byte_index & 3;
			if (reading && slot == SLOT_DATA)
				slot = SLOT_DEV_READ;
			tx_shift  = req_bytes[slot];
			bit_count = '0;
		endfunction

		function result_t step_sequencer(item_t t);
			result_t r;
			logic    done;
			done = 1'b0;
			if (phase == SEQ_IDLE && t.start_request) begin
				reading                   = t.kind;
				req_bytes[SLOT_DEV_WRITE] = t.device_write_byte;
				req_bytes[SLOT_ADDR_HIGH] = t.address_high;
				req_bytes[SLOT_ADDR_LOW]  = t.address_low;
				req_bytes[SLOT_DATA]      = t.write_data;
				req_bytes[SLOT_DEV_READ]  = t.device_read_byte;
				ack_lost                  = 1'b0;
				byte_index                = '0;
				load_byte();
				phase = START_SDA_HIGH;
			end
			case (phase)
				START_SDA_HIGH: begin
					sda_drive = 1'b1;
					phase = START_SCL_HIGH;
				end
				START_SCL_HIGH: begin
					scl_drive = 1'b1;
					phase = START_SDA_LOW;
				end
				START_SDA_LOW: begin
					sda_drive = 1'b0;
					phase = BIT_SCL_LOW;
				end
				BIT_SCL_LOW: begin
					scl_drive = 1'b0;
					phase = BIT_DATA;
				end
				BIT_DATA: begin
					sda_drive = tx_shift[7];
					phase = BIT_SCL_HIGH;
				end
				BIT_SCL_HIGH: begin
					scl_drive = 1'b1;
					phase = BIT_SCL_FALL;
				end
				BIT_SCL_FALL: begin
					scl_drive = 1'b0;
					tx_shift  = tx_shift << 1;
					bit_count = bit_count + 4'd1;
					if (bit_count >= 4'd8)
						phase = ACK_RELEASE;
					else
						phase = BIT_SCL_LOW;
				end
				ACK_RELEASE: begin
					sda_drive  = 1'b1;
					wait_count = '0;
					phase = ACK_CLOCK;
				end
				ACK_CLOCK: begin
					scl_drive = 1'b1;
					phase = ACK_POLL;
				end
				ACK_POLL: begin
					if (!t.sda_in) begin
						phase = ACK_FALL;
					end else if (wait_count < ack_limit) begin
						wait_count = wait_count + 8'd1;
					end else begin
						ack_lost = 1'b1;
						phase = ACK_FALL;
					end
				end
				ACK_FALL: begin
					scl_drive = 1'b0;
					if (byte_index < 3'd3) begin
						byte_index = byte_index + 3'd1;
						load_byte();
						// a read turns around with a repeated START before the read byte
						if (reading && byte_index == 3'd3)
							phase = START_SDA_HIGH;
						else
							phase = BIT_SCL_LOW;
					end else if (reading) begin
						bit_count = '0;
						phase = RX_RELEASE;
					end else begin
						phase = STOP_SDA_LOW;
					end
				end
				RX_RELEASE: begin
					sda_drive = 1'b1;
					phase = RX_SCL_LOW;
				end
				RX_SCL_LOW: begin
					scl_drive = 1'b0;
					phase = RX_SCL_HIGH;
				end
				RX_SCL_HIGH: begin
					scl_drive = 1'b1;
					rx_shift  = {rx_shift[6:0], t.sda_in};
					bit_count = bit_count + 4'd1;
					if (bit_count >= 4'd8)
						phase = NACK_LOW;
					else
						phase = RX_RELEASE;
				end
				NACK_LOW: begin
					scl_drive = 1'b0;
					sda_drive = 1'b1;
					phase = NACK_HIGH;
				end
				NACK_HIGH: begin
					scl_drive = 1'b1;
					phase = NACK_FALL;
				end
				NACK_FALL: begin
					scl_drive = 1'b0;
					phase = STOP_SDA_LOW;
				end
				STOP_SDA_LOW: begin
					sda_drive = 1'b0;
					phase = STOP_SCL_HIGH;
				end
				STOP_SCL_HIGH: begin
					scl_drive = 1'b1;
					phase = STOP_SDA_HIGH;
				end
				STOP_SDA_HIGH: begin
					sda_drive = 1'b1;
					done = 1'b1;
					phase = SEQ_IDLE;
				end
				default: begin
					phase = SEQ_IDLE;
				end
			endcase
			r.scl_level   = scl_drive;
			r.sda_level   = sda_drive;
			r.busy_res    = (phase != SEQ_IDLE);
			r.done_res    = done;
			r.read_data   = rx_shift;
			r.ack_missing = ack_lost;
			return r;
		endfunction

		function void note_tick(item_t t);
			expected_levels.push_back(step_sequencer(t));
		endfunction

		function void check_levels(logic [OUT_DATA_W-1:0] d);
			result_t want;
			result_t got;
			got.scl_level   = d[0];
			got.sda_level   = d[1];
			got.busy_res    = d[2];
			got.done_res    = d[3];
			got.read_data   = d[11:4];
			got.ack_missing = d[12];
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected output transaction: %h", d);
				return;
			end
			want = expected_levels.pop_front();
			if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
			    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
			    got.read_data !== want.read_data || got.ack_missing !== want.ack_missing) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("levels mismatch: exp scl %0d sda %0d busy %0d done %0d rd %02h nack %0d",
					         want.scl_level, want.sda_level, want.busy_res, want.done_res,
					         want.read_data, want.ack_missing);
					$display("                 got scl %0d sda %0d busy %0d done %0d rd %02h nack %0d",
					         got.scl_level, got.sda_level, got.busy_res, got.done_res,
					         got.read_data, got.ack_missing);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [7:0]             cfg_write_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;

	i2c_level_scoreboard board;

	bit steady_run;     // last part of the run: no idling on either side
	bit hold_sda_high;  // current transaction: slave never acknowledges
	bit noisy_txn;      // current transaction: SDA random in every phase

	i2c_eeprom_random_access_master dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Next phase tick, shaped by where the predicted sequencer stands.
	// Request bytes are always random: they are latched on a start when
	// idle and must be ignored on a start while busy.
	function automatic item_t next_tick();
		item_t t;
		t.kind              = 1'($urandom_range(0, 1));
		t.device_write_byte = 8'($urandom);
		t.device_read_byte  = 8'($urandom);
		t.address_high      = 8'($urandom);
		t.address_low       = 8'($urandom);
		t.write_data        = 8'($urandom);
		if (board.phase == SEQ_IDLE) begin
			t.start_request = ($urandom_range(0, 3) != 0);
			if (t.start_request) begin
				hold_sda_high = ($urandom_range(0, 7) == 0);
				noisy_txn     = ($urandom_range(0, 9) == 0);
			end
		end else begin
			t.start_request = 1'($urandom_range(0, 1));
		end
		// SDA only matters in ACK polls and on read bits
		if (noisy_txn || board.phase != ACK_POLL)
			t.sda_in = 1'($urandom_range(0, 1));
		else
			t.sda_in = hold_sda_high ? 1'b1 : ($urandom_range(0, 3) == 0);
		return t;
	endfunction

	// Offer one tick and hold it until the block takes it
	task automatic send_tick(input item_t t);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({t.sda_in, t.write_data, t.address_low, t.address_high,
		                        t.device_read_byte, t.device_write_byte, t.start_request});
		s_tuser  <= t.kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_tick(t);
	endtask

	task automatic run_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			send_tick(next_tick());
			if (!steady_run && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	endtask

	// Finish the running transaction, let the results drain, then write
	// the timeout register while the sequencer sits idle.
	task automatic apply_timeout(input logic [7:0] value);
		while (board.phase != SEQ_IDLE) send_tick(next_tick());
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		board.set_timeout(value);
		@(posedge clk);
	endtask

	// Sender side and run control
	initial begin
		item_t t;
		arst_n         <= 1'b0;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= '0;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		s_tuser        <= 1'b0;
		steady_run    = 1'b0;
		hold_sda_high = 1'b0;
		noisy_txn     = 1'b0;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle ticks with extreme fields, no start
		t = '0;
		send_tick(t);
		t = '1;
		t.start_request = 1'b0;
		send_tick(t);
		// read started from idle with every request byte at all ones
		t = '1;
		send_tick(t);
		// start strobes while busy with other bytes: ignored, nothing latched
		for (int i = 0; i < 20; i++) begin
			t = '0;
			t.start_request = 1'b1;
			t.kind          = i[1];
			t.sda_in        = i[0];
			send_tick(t);
		end

		// random part, swept over timeout settings including both extremes;
		// finishing each transaction before a register write adds more ticks
		run_ticks(200);
		apply_timeout(8'd0);
		run_ticks(150);
		apply_timeout(8'd1);
		run_ticks(150);
		apply_timeout(8'd255);
		run_ticks(200);
		apply_timeout(8'($urandom_range(2, 254)));
		run_ticks(150);
		apply_timeout(8'd3);
		steady_run = 1'b1;
		run_ticks(150);
		s_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver side: random stall bursts, plus one long hold-off that
	// backs the block up until it stops taking input.
	initial begin
		int  stall_left;
		int  seen;
		bit  pressure_done;
		stall_left    = 0;
		seen          = 0;
		pressure_done = 1'b0;
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				board.check_levels(m_tdata);
				seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					m_tready <= 1'b1;
			end else if (!steady_run && !pressure_done && seen >= 200) begin
				pressure_done = 1'b1;
				stall_left    = 300;
				m_tready <= 1'b0;
			end else if (!steady_run && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if neither side moves a transaction for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
